// ===== hw/rtl/icmpf_pkg.sv =====
// shared constants and types for the icmp echo sequence parity filter
`default_nettype none

package icmpf_pkg;

   // frame limit default, in bytes
   localparam int unsigned MAX_FRAME_BYTES = 16383;

   // ethertypes and protocol numbers
   localparam logic [15:0] KIND_IPV4    = 16'h0800;
   localparam logic [15:0] KIND_IPV6    = 16'h86DD;
   localparam logic [7:0]  PROTO_ICMP   = 8'd1;
   localparam logic [7:0]  PROTO_ICMPV6 = 8'd58;

   // header layout
   localparam int unsigned KIND_HI_OFFSET = 12;
   localparam int unsigned KIND_LO_OFFSET = 13;
   localparam int unsigned ETH_LEN        = 14;
   localparam int unsigned IPV4_MIN_LEN   = 20;
   localparam int unsigned IPV4_PROTO_POS = 9;
   localparam int unsigned IPV6_NEXT_POS  = 6;
   localparam int unsigned IPV6_LEN       = 40;
   localparam int unsigned ICMP_LEN       = 8;
   localparam int unsigned SEQ_HI_POS     = 6;
   localparam int unsigned SEQ_LO_POS     = 7;

   // packet class codes
   localparam logic [2:0] CLASS_OTHER      = 3'd0;
   localparam logic [2:0] CLASS_IPV4       = 3'd1;
   localparam logic [2:0] CLASS_ICMPV4     = 3'd2;
   localparam logic [2:0] CLASS_IPV6       = 3'd3;
   localparam logic [2:0] CLASS_ICMPV6     = 3'd4;

   typedef struct packed {
      logic        drop;
      logic [2:0]  packet_class;
      logic [15:0] echo_sequence;
   } verdict_type;

endpackage

`default_nettype wire

// ===== hw/rtl/icmp_echo_sequence_parity_filter.sv =====
// top level: byte-stream icmp echo sequence parity filter
//
//  channel  direction  ports                                   carries
//  req      in         req_valid, req_stall, req_data_byte,    one frame byte per transfer
//                      req_last_byte
//  rsp      out        rsp_valid, rsp_stall, rsp_drop,         one verdict per frame
//                      rsp_packet_class, rsp_echo_sequence
//
// one byte per cycle is taken while req_stall is low; each byte sits in the input
// register while the parser updates, and the verdict of a frame lands in the result
// register as the last byte leaves the input register, which raises rsp_valid.
// reset clears the parse state, so the next byte opens a new frame.
// a stalled verdict holds the result register; bytes still flow until a last byte
// reaches the input register, which then waits for the result register to free up.
`default_nettype none

module icmp_echo_sequence_parity_filter #(
   parameter int unsigned MaxFrameBytes = icmpf_pkg::MAX_FRAME_BYTES
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_drop,
   output logic [2:0]       rsp_packet_class,
   output logic [15:0]      rsp_echo_sequence
);

   logic                   in_valid_ff;
   logic [7:0]             in_data_ff;
   logic                   in_last_ff;
   logic                   out_valid_ff;
   icmpf_pkg::verdict_type out_verdict_ff;
   icmpf_pkg::verdict_type verdict;
   logic                   out_free;
   logic                   in_go;

   // a non-last byte never needs the result register
   assign out_free  = ~out_valid_ff | ~rsp_stall;
   assign in_go     = in_valid_ff & (~in_last_ff | out_free);
   assign req_stall = in_valid_ff & ~in_go;

   icmpf_parser #(
      .MaxFrameBytes (MaxFrameBytes)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (in_go),
      .step_data (in_data_ff),
      .step_last (in_last_ff),
      .verdict   (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (~req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_go & in_last_ff;
      end
      if (out_free && in_go && in_last_ff) begin
         out_verdict_ff <= verdict;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_drop          = out_verdict_ff.drop;
   assign rsp_packet_class  = out_verdict_ff.packet_class;
   assign rsp_echo_sequence = out_verdict_ff.echo_sequence;

endmodule

`default_nettype wire

// ===== hw/rtl/icmpf_parser.sv =====
// per-frame header parse state and the end-of-frame verdict
`default_nettype none

module icmpf_parser #(
   parameter int unsigned MaxFrameBytes = icmpf_pkg::MAX_FRAME_BYTES
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire logic [7:0]             step_data,
   input  wire logic                   step_last,
   output icmpf_pkg::verdict_type      verdict
);

   localparam int unsigned OffsetWidth = $clog2(MaxFrameBytes + 1);

   typedef enum logic [1:0] {
      PHASE_ETH,
      PHASE_IPV4,
      PHASE_IPV6,
      PHASE_OTHER
   } phase_type;

   logic [OffsetWidth-1:0] offset_ff, offset_in;
   logic [15:0]            kind_ff, kind_in;
   logic [5:0]             ihl_ff, ihl_in;
   logic [7:0]             proto_ff, proto_in;
   logic [15:0]            seq_ff, seq_in;
   phase_type              phase_ff, phase_in;
   logic [OffsetWidth-1:0] seq_base;
   logic                   active;

   always_comb begin
      offset_in = offset_ff;
      kind_in   = kind_ff;
      ihl_in    = ihl_ff;
      proto_in  = proto_ff;
      seq_in    = seq_ff;
      phase_in  = phase_ff;
      seq_base  = OffsetWidth'(icmpf_pkg::ETH_LEN + icmpf_pkg::IPV6_LEN);
      active    = offset_ff < OffsetWidth'(MaxFrameBytes);
      if (active) begin
         if (offset_ff == OffsetWidth'(icmpf_pkg::KIND_HI_OFFSET)) begin
            kind_in = {step_data, 8'h00};
         end
         if (offset_ff == OffsetWidth'(icmpf_pkg::KIND_LO_OFFSET)) begin
            kind_in = {kind_ff[15:8], step_data};
            if (kind_in == icmpf_pkg::KIND_IPV4) begin
               phase_in = PHASE_IPV4;
            end else if (kind_in == icmpf_pkg::KIND_IPV6) begin
               phase_in = PHASE_IPV6;
            end else begin
               phase_in = PHASE_OTHER;
            end
         end
         unique case (phase_in)
            PHASE_IPV4: begin
               if (offset_ff == OffsetWidth'(icmpf_pkg::ETH_LEN)) begin
                  ihl_in = {step_data[3:0], 2'b00};
               end
               if (offset_ff == OffsetWidth'(icmpf_pkg::ETH_LEN + icmpf_pkg::IPV4_PROTO_POS))
               begin
                  proto_in = step_data;
               end
               // stored ihl is good enough: the ihl byte can never be a sequence byte
               seq_base = OffsetWidth'(icmpf_pkg::ETH_LEN) + OffsetWidth'(ihl_ff);
            end
            PHASE_IPV6: begin
               if (offset_ff == OffsetWidth'(icmpf_pkg::ETH_LEN + icmpf_pkg::IPV6_NEXT_POS))
               begin
                  proto_in = step_data;
               end
            end
            default: begin
            end
         endcase
         if (phase_in == PHASE_IPV4 || phase_in == PHASE_IPV6) begin
            if (offset_ff == seq_base + OffsetWidth'(icmpf_pkg::SEQ_HI_POS)) begin
               seq_in[15:8] = step_data;
            end
            if (offset_ff == seq_base + OffsetWidth'(icmpf_pkg::SEQ_LO_POS)) begin
               seq_in[7:0] = step_data;
            end
         end
         offset_in = offset_ff + 1'b1;
      end
   end

   // verdict from the state as it stands after this byte
   always_comb begin
      verdict.drop          = 1'b0;
      verdict.packet_class  = icmpf_pkg::CLASS_OTHER;
      verdict.echo_sequence = 16'h0000;
      if (phase_in == PHASE_IPV4 &&
          offset_in >= OffsetWidth'(icmpf_pkg::ETH_LEN + icmpf_pkg::IPV4_MIN_LEN)) begin
         if (proto_in != icmpf_pkg::PROTO_ICMP) begin
            verdict.packet_class = icmpf_pkg::CLASS_IPV4;
         end else if (offset_in >= OffsetWidth'(icmpf_pkg::ETH_LEN + icmpf_pkg::ICMP_LEN)
                                   + OffsetWidth'(ihl_in)) begin
            verdict.packet_class  = icmpf_pkg::CLASS_ICMPV4;
            verdict.echo_sequence = seq_in;
            verdict.drop          = ~seq_in[0];
         end
      end else if (phase_in == PHASE_IPV6 &&
                   offset_in >= OffsetWidth'(icmpf_pkg::ETH_LEN + icmpf_pkg::IPV6_LEN)) begin
         if (proto_in != icmpf_pkg::PROTO_ICMPV6) begin
            verdict.packet_class = icmpf_pkg::CLASS_IPV6;
         end else if (offset_in >= OffsetWidth'(icmpf_pkg::ETH_LEN + icmpf_pkg::IPV6_LEN
                                                + icmpf_pkg::ICMP_LEN)) begin
            verdict.packet_class  = icmpf_pkg::CLASS_ICMPV6;
            verdict.echo_sequence = seq_in;
            verdict.drop          = ~seq_in[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && step_last)) begin
         offset_ff <= '0;
         kind_ff   <= '0;
         ihl_ff    <= '0;
         proto_ff  <= '0;
         seq_ff    <= '0;
         phase_ff  <= PHASE_ETH;
      end else if (step) begin
         offset_ff <= offset_in;
         kind_ff   <= kind_in;
         ihl_ff    <= ihl_in;
         proto_ff  <= proto_in;
         seq_ff    <= seq_in;
         phase_ff  <= phase_in;
      end
   end

endmodule

`default_nettype wire

// ===== tb/icmp_echo_sequence_parity_filter_tb.sv =====
// testbench for the icmp echo sequence parity filter: frame stimulus, verdict predictor, checks
`default_nettype none

module icmp_echo_sequence_parity_filter_tb;

   typedef enum logic [2:0] {
      PH_ETH,
      PH_IPV4,
      PH_IPV6,
      PH_OTHER
   } parse_phase_type;

   // predicts one verdict per frame from the transferred bytes and checks the block's verdicts
   class verdict_board_type;
      logic [13:0]            frame_offset;
      logic [15:0]            ether_kind;
      logic [5:0]             ip_hdr_bytes;
      logic [7:0]             ip_proto;
      logic [15:0]            seq_hold;
      parse_phase_type        phase;
      icmpf_pkg::verdict_type pending[$];
      int                     errors;
      int                     verdicts_seen;

      function new();
         errors = 0;
         verdicts_seen = 0;
         clear();
      endfunction

      function void clear();
         frame_offset = '0;
         ether_kind = '0;
         ip_hdr_bytes = '0;
         ip_proto = '0;
         seq_hold = '0;
         phase = PH_ETH;
      endfunction

      task report(input string what);
         $display("%0t: verdict %0d: %s", $time, verdicts_seen, what);
         errors++;
      endtask

      task note_byte(input logic [7:0] d, input logic last);
         int unsigned n;
         int unsigned base;
         bit in_ip;
         icmpf_pkg::verdict_type v;
         in_ip = 1'b0;
         base = 0;
         if (frame_offset < icmpf_pkg::MAX_FRAME_BYTES) begin
            if (frame_offset == icmpf_pkg::KIND_HI_OFFSET) ether_kind = {d, 8'h00};
            if (frame_offset == icmpf_pkg::KIND_LO_OFFSET) begin
               ether_kind[7:0] = d;
               if (ether_kind == icmpf_pkg::KIND_IPV4) phase = PH_IPV4;
               else if (ether_kind == icmpf_pkg::KIND_IPV6) phase = PH_IPV6;
               else phase = PH_OTHER;
            end
            if (phase == PH_IPV4) begin
               if (frame_offset == icmpf_pkg::ETH_LEN) ip_hdr_bytes = {d[3:0], 2'b00};
               if (frame_offset == icmpf_pkg::ETH_LEN + icmpf_pkg::IPV4_PROTO_POS)
                  ip_proto = d;
               base = icmpf_pkg::ETH_LEN + ip_hdr_bytes;
               in_ip = 1'b1;
            end else if (phase == PH_IPV6) begin
               if (frame_offset == icmpf_pkg::ETH_LEN + icmpf_pkg::IPV6_NEXT_POS)
                  ip_proto = d;
               base = icmpf_pkg::ETH_LEN + icmpf_pkg::IPV6_LEN;
               in_ip = 1'b1;
            end
            if (in_ip && frame_offset == base + icmpf_pkg::SEQ_HI_POS) seq_hold[15:8] = d;
            if (in_ip && frame_offset == base + icmpf_pkg::SEQ_LO_POS) seq_hold[7:0] = d;
            frame_offset++;
         end
         if (!last) return;

         n = frame_offset;
         v = '0;
         v.packet_class = icmpf_pkg::CLASS_OTHER;
         if (phase == PH_IPV4 && n >= icmpf_pkg::ETH_LEN + icmpf_pkg::IPV4_MIN_LEN) begin
            if (ip_proto != icmpf_pkg::PROTO_ICMP) begin
               v.packet_class = icmpf_pkg::CLASS_IPV4;
            end else if (n >= icmpf_pkg::ETH_LEN + ip_hdr_bytes + icmpf_pkg::ICMP_LEN) begin
               v.packet_class = icmpf_pkg::CLASS_ICMPV4;
               v.echo_sequence = seq_hold;
               v.drop = ~seq_hold[0];
            end
         end else if (phase == PH_IPV6 && n >= icmpf_pkg::ETH_LEN + icmpf_pkg::IPV6_LEN) begin
            if (ip_proto != icmpf_pkg::PROTO_ICMPV6) begin
               v.packet_class = icmpf_pkg::CLASS_IPV6;
            end else if (n >= icmpf_pkg::ETH_LEN + icmpf_pkg::IPV6_LEN
                              + icmpf_pkg::ICMP_LEN) begin
               v.packet_class = icmpf_pkg::CLASS_ICMPV6;
               v.echo_sequence = seq_hold;
               v.drop = ~seq_hold[0];
            end
         end
         pending.push_back(v);
         clear();
      endtask

      task check_verdict(input logic drop, input logic [2:0] pclass, input logic [15:0] seq);
         icmpf_pkg::verdict_type want;
         verdicts_seen++;
         if (pending.size() == 0) begin
            report($sformatf("unexpected verdict drop=%0b class=%0d seq=%h", drop, pclass, seq));
            return;
         end
         want = pending.pop_front();
         if (drop !== want.drop)
            report($sformatf("drop %b, want %b", drop, want.drop));
         if (pclass !== want.packet_class)
            report($sformatf("packet_class %0d, want %0d", pclass, want.packet_class));
         if (seq !== want.echo_sequence)
            report($sformatf("echo_sequence %h, want %h", seq, want.echo_sequence));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = '0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_drop;
   logic [2:0]  rsp_packet_class;
   logic [15:0] rsp_echo_sequence;

   verdict_board_type board = new();
   bit quiet = 1'b0;
   bit calm_frame = 1'b0;
   int frames_sent = 0;
   int bytes_sent = 0;

   icmp_echo_sequence_parity_filter i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_drop          (rsp_drop),
      .rsp_packet_class  (rsp_packet_class),
      .rsp_echo_sequence (rsp_echo_sequence)
   );

   always #2 clock = ~clock;

   task automatic push_byte(input logic [7:0] b, input logic last);
      if (!calm_frame && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (req_stall);
      board.note_byte(b, last);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [15:0] kind, input logic [3:0] ihl,
                             input logic [7:0] proto, input logic [15:0] seq, input int len);
      logic [7:0] frame_bytes[$];
      int unsigned base;
      bit has_ip;
      has_ip = 1'b0;
      base = 0;
      for (int k = 0; k < len; k++) frame_bytes.push_back(8'($urandom));
      if (len > icmpf_pkg::KIND_HI_OFFSET) frame_bytes[icmpf_pkg::KIND_HI_OFFSET] = kind[15:8];
      if (len > icmpf_pkg::KIND_LO_OFFSET) frame_bytes[icmpf_pkg::KIND_LO_OFFSET] = kind[7:0];
      if (kind == icmpf_pkg::KIND_IPV4) begin
         // version nibble stays random, the parser ignores it
         if (len > icmpf_pkg::ETH_LEN)
            frame_bytes[icmpf_pkg::ETH_LEN] = {frame_bytes[icmpf_pkg::ETH_LEN][7:4], ihl};
         if (len > icmpf_pkg::ETH_LEN + icmpf_pkg::IPV4_PROTO_POS)
            frame_bytes[icmpf_pkg::ETH_LEN + icmpf_pkg::IPV4_PROTO_POS] = proto;
         base = icmpf_pkg::ETH_LEN + 4 * int'(ihl);
         has_ip = 1'b1;
      end else if (kind == icmpf_pkg::KIND_IPV6) begin
         if (len > icmpf_pkg::ETH_LEN + icmpf_pkg::IPV6_NEXT_POS)
            frame_bytes[icmpf_pkg::ETH_LEN + icmpf_pkg::IPV6_NEXT_POS] = proto;
         base = icmpf_pkg::ETH_LEN + icmpf_pkg::IPV6_LEN;
         has_ip = 1'b1;
      end
      if (has_ip && len > base + icmpf_pkg::SEQ_HI_POS)
         frame_bytes[base + icmpf_pkg::SEQ_HI_POS] = seq[15:8];
      if (has_ip && len > base + icmpf_pkg::SEQ_LO_POS)
         frame_bytes[base + icmpf_pkg::SEQ_LO_POS] = seq[7:0];
      calm_frame = quiet || $urandom_range(0, 3) == 0;
      foreach (frame_bytes[k]) push_byte(frame_bytes[k], k == len - 1);
      frames_sent++;
   endtask

   task automatic send_random_frame();
      logic [15:0] kind;
      logic [3:0]  ihl;
      logic [7:0]  proto;
      int          full;
      int          pick;
      int          len;
      pick = $urandom_range(0, 99);
      ihl = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'd5;
      if (pick < 42) begin
         kind = icmpf_pkg::KIND_IPV4;
         proto = ($urandom_range(0, 9) == 0) ? 8'($urandom) : icmpf_pkg::PROTO_ICMP;
         full = icmpf_pkg::ETH_LEN + 4 * int'(ihl) + icmpf_pkg::ICMP_LEN;
         if (full < icmpf_pkg::ETH_LEN + icmpf_pkg::IPV4_MIN_LEN)
            full = icmpf_pkg::ETH_LEN + icmpf_pkg::IPV4_MIN_LEN;
      end else if (pick < 80) begin
         kind = icmpf_pkg::KIND_IPV6;
         proto = ($urandom_range(0, 9) == 0) ? 8'($urandom) : icmpf_pkg::PROTO_ICMPV6;
         full = icmpf_pkg::ETH_LEN + icmpf_pkg::IPV6_LEN + icmpf_pkg::ICMP_LEN;
      end else begin
         kind = 16'($urandom);
         proto = 8'($urandom);
         full = $urandom_range(14, 80);
      end
      // mostly complete frames with trailing payload, some cut short anywhere
      if ($urandom_range(0, 7) == 0) len = $urandom_range(1, full - 1);
      else len = full + $urandom_range(0, 30);
      send_frame(kind, ihl, proto, 16'($urandom), len);
   endtask

   // verdict side: check each transfer, stall in random bursts
   initial begin : verdict_sink
      int stall_left;
      stall_left = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall)
            board.check_verdict(rsp_drop, rsp_packet_class, rsp_echo_sequence);
         if (quiet) stall_left = 0;
         else if (stall_left == 0 && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 19);
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : byte_source
      int drain_cycles;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // short frames and byte-swapped or foreign ethertypes
      send_frame(icmpf_pkg::KIND_IPV4, 4'd5, icmpf_pkg::PROTO_ICMP, 16'h0001, 1);
      send_frame(icmpf_pkg::KIND_IPV4, 4'd5, icmpf_pkg::PROTO_ICMP, 16'h0001, 13);
      send_frame(16'h0008, 4'd5, icmpf_pkg::PROTO_ICMP, 16'h0002, 40);
      send_frame(16'hDD86, 4'd0, icmpf_pkg::PROTO_ICMPV6, 16'h0002, 40);
      send_frame(16'hFFFF, 4'd0, 8'hFF, 16'h0000, 20);
      // ipv4: truncated header, plain, icmp odd and even, truncated icmp
      send_frame(icmpf_pkg::KIND_IPV4, 4'd5, 8'd6, 16'h0000, 33);
      send_frame(icmpf_pkg::KIND_IPV4, 4'd5, 8'd6, 16'h0000, 34);
      send_frame(icmpf_pkg::KIND_IPV4, 4'd5, icmpf_pkg::PROTO_ICMP, 16'hFFFF, 42);
      send_frame(icmpf_pkg::KIND_IPV4, 4'd5, icmpf_pkg::PROTO_ICMP, 16'h0000, 42);
      send_frame(icmpf_pkg::KIND_IPV4, 4'd5, icmpf_pkg::PROTO_ICMP, 16'h8001, 41);
      // ihl below five overlaps the ip header, ihl fifteen fills it out, icmpv6 in ipv4 stays plain
      send_frame(icmpf_pkg::KIND_IPV4, 4'd0, icmpf_pkg::PROTO_ICMP, 16'h1234, 34);
      send_frame(icmpf_pkg::KIND_IPV4, 4'd3, icmpf_pkg::PROTO_ICMP, 16'hABCD, 34);
      send_frame(icmpf_pkg::KIND_IPV4, 4'd15, icmpf_pkg::PROTO_ICMP, 16'h7FFF, 82);
      send_frame(icmpf_pkg::KIND_IPV4, 4'd15, icmpf_pkg::PROTO_ICMP, 16'h7FFE, 81);
      send_frame(icmpf_pkg::KIND_IPV4, 4'd5, icmpf_pkg::PROTO_ICMPV6, 16'h0001, 34);
      // ipv6 counterparts
      send_frame(icmpf_pkg::KIND_IPV6, 4'd0, 8'd17, 16'h0000, 53);
      send_frame(icmpf_pkg::KIND_IPV6, 4'd0, 8'd17, 16'h0000, 54);
      send_frame(icmpf_pkg::KIND_IPV6, 4'd0, icmpf_pkg::PROTO_ICMP, 16'h0005, 54);
      send_frame(icmpf_pkg::KIND_IPV6, 4'd0, icmpf_pkg::PROTO_ICMPV6, 16'hFFFF, 62);
      send_frame(icmpf_pkg::KIND_IPV6, 4'd0, icmpf_pkg::PROTO_ICMPV6, 16'hFFFE, 62);
      send_frame(icmpf_pkg::KIND_IPV6, 4'd0, icmpf_pkg::PROTO_ICMPV6, 16'h0001, 61);

      while (bytes_sent < 960) send_random_frame();
      quiet = 1'b1;
      repeat (2) send_random_frame();
      req_valid <= 1'b0;

      drain_cycles = 0;
      while (board.pending.size() != 0 && drain_cycles < 10000) begin
         @(posedge clock);
         drain_cycles++;
      end
      if (board.pending.size() != 0)
         board.report($sformatf("%0d verdicts never arrived", board.pending.size()));
      repeat (8) @(posedge clock);
      if (board.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : watchdog
      #6000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire
